// ===== design/mmop_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mmop_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int LVL_W           = 4;
	localparam int IDX_W           = 13;
	localparam int SIZE_W          = 14;
	localparam int CNT_W           = 24;
	localparam int BASE_W          = 16;
	localparam int STRIDE_W        = 12;
	localparam int SPB_W           = BASE_W + STRIDE_W;
	localparam int SAMPLES_W       = 35;
	localparam int FILL_W          = 12;
	localparam int MAX_TOP_BUCKETS = 8192;
	localparam int TOP_SHIFT       = $clog2(MAX_TOP_BUCKETS);
	localparam int STOP_SIZE       = 32;
	localparam int MAX_LEVELS      = 9;
	localparam int NUM_W           = CNT_W + 1;
	localparam int DIV_CNT_W       = $clog2(NUM_W + 1);
	localparam int REM_W           = STRIDE_W;
	localparam int CFG_IDX_W       = 2;
	localparam int BASE_RESET      = 256;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd1;

	typedef enum logic [1:0] {
		SETUP_IDLE,
		SETUP_START,
		SETUP_DIV,
		SETUP_SIZE
	} setup_state_t;

	typedef struct packed {
		logic [CNT_W-1:0]                   count;
		logic [STRIDE_W-1:0]                stride;
		logic [SPB_W-1:0]                   spb;
		logic [MAX_LEVELS-1:0][SIZE_W-1:0]  size;
		logic [MAX_LEVELS-1:0]              has_next;
	} geom_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mn;
		logic signed [SAMPLE_W-1:0] mx;
	} close_t;

endpackage
`default_nettype wire

// ===== design/min_max_overview_pyramid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Builds a min/max overview pyramid from a stream of (min, max) bucket pairs. Write the
// pair count (register 0, which also restarts the stream) and the samples per pair
// (register 1) first; after any register write the block computes the stride and the
// level sizes with a bit-serial divider and holds s_axis_tready low while it does so.
// Pairs are then taken one per cycle unless the result walk or m_axis_tready holds
// them. A pair that closes a level-0 bucket releases between 1 and 9 result buckets,
// one per cycle through the output register while m_axis_tready allows, as the walk
// climbs the levels; the next closing pair waits until that walk issues its last result.
// Pairs beyond the configured count are taken and dropped.
module min_max_overview_pyramid (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [23:0] cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // sample_min, sample_max
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [79:0] m_axis_tdata,  // bucket_index, bucket_min, bucket_max, samples_in_bucket
	output logic [3:0]  m_axis_tuser,  // level
	output logic        m_axis_tlast   // last_of_run
);

	mmop_pkg::geom_t  geom;
	mmop_pkg::close_t close;
	logic             busy;
	logic             clear;
	logic             cfg_fire;
	logic             close_valid;
	logic             close_ready;

	logic [mmop_pkg::IDX_W-1:0]     out_index;
	logic [mmop_pkg::SAMPLE_W-1:0]  out_min;
	logic [mmop_pkg::SAMPLE_W-1:0]  out_max;
	logic [mmop_pkg::SAMPLES_W-1:0] out_samples;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	mmop_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_fire),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (busy),
		.clear     (clear)
	);

	mmop_group u_group (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clear),
		.busy        (busy),
		.geom        (geom),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_min      (s_axis_tdata[15:0]),
		.in_max      (s_axis_tdata[31:16]),
		.close_valid (close_valid),
		.close_ready (close_ready),
		.close       (close)
	);

	mmop_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clear),
		.geom        (geom),
		.close_valid (close_valid),
		.close_ready (close_ready),
		.close       (close),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_level   (m_axis_tuser),
		.out_index   (out_index),
		.out_min     (out_min),
		.out_max     (out_max),
		.out_samples (out_samples),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {out_samples, out_max, out_min, out_index};

endmodule
`default_nettype wire

// ===== design/mmop_setup.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mmop_setup (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	input  wire [mmop_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [mmop_pkg::CNT_W-1:0]          cfg_data,
	output mmop_pkg::geom_t                    geom,
	output logic                               busy,
	output logic                               clear
);

	mmop_pkg::setup_state_t state_q, state_d;

	logic [mmop_pkg::CNT_W-1:0]                       count_q;
	logic [mmop_pkg::BASE_W-1:0]                      base_q;
	logic [mmop_pkg::STRIDE_W-1:0]                    stride_q;
	logic [mmop_pkg::SPB_W-1:0]                       spb_q;
	logic [mmop_pkg::MAX_LEVELS-1:0][mmop_pkg::SIZE_W-1:0] size_q;
	logic [mmop_pkg::MAX_LEVELS-1:0]                  has_next_q;
	logic [mmop_pkg::NUM_W-1:0]                       num_q;
	logic [mmop_pkg::REM_W-1:0]                       rem_q;
	logic [mmop_pkg::DIV_CNT_W-1:0]                   div_cnt_q;
	logic [mmop_pkg::LVL_W-1:0]                       k_q;
	logic [mmop_pkg::SIZE_W-1:0]                      cur_size_q;
	logic                                             cur_exists_q;

	logic [mmop_pkg::NUM_W-1:0]    stride_wide;
	logic [mmop_pkg::STRIDE_W-1:0] stride_c;
	logic [mmop_pkg::REM_W:0]      rem_shift;
	logic                          rem_ge;
	logic [mmop_pkg::REM_W:0]      rem_sub;
	logic [mmop_pkg::NUM_W-1:0]    num_next;
	logic                          nxt_exists;
	logic [mmop_pkg::SIZE_W:0]     half_sum;
	logic [mmop_pkg::SIZE_W-1:0]   nxt_size;
	logic [mmop_pkg::LVL_W-1:0]    k_prev;

	assign clear = cfg_valid && (cfg_index == mmop_pkg::REG_COUNT);
	assign busy  = (state_q != mmop_pkg::SETUP_IDLE);

	// stride = max(1, ceil(count / top buckets))
	always_comb begin
		stride_wide = ({1'b0, count_q} + mmop_pkg::NUM_W'(mmop_pkg::MAX_TOP_BUCKETS - 1))
			>> mmop_pkg::TOP_SHIFT;
		stride_c = (stride_wide == '0) ? mmop_pkg::STRIDE_W'(1)
			: stride_wide[mmop_pkg::STRIDE_W-1:0];
	end

	always_comb begin
		rem_shift = {rem_q, num_q[mmop_pkg::NUM_W-1]};
		rem_ge    = rem_shift >= {1'b0, stride_q};
		rem_sub   = rem_ge ? (rem_shift - {1'b0, stride_q}) : rem_shift;
		num_next  = {num_q[mmop_pkg::NUM_W-2:0], rem_ge};
	end

	always_comb begin
		nxt_exists = cur_exists_q && (cur_size_q > mmop_pkg::SIZE_W'(mmop_pkg::STOP_SIZE));
		half_sum   = {1'b0, cur_size_q} + (mmop_pkg::SIZE_W + 1)'(1);
		nxt_size   = nxt_exists ? half_sum[mmop_pkg::SIZE_W:1] : '0;
		k_prev     = k_q - mmop_pkg::LVL_W'(1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mmop_pkg::SETUP_IDLE: begin
				if (cfg_valid) begin
					state_d = mmop_pkg::SETUP_START;
				end
			end
			mmop_pkg::SETUP_START: begin
				state_d = mmop_pkg::SETUP_DIV;
			end
			mmop_pkg::SETUP_DIV: begin
				if (div_cnt_q == mmop_pkg::DIV_CNT_W'(mmop_pkg::NUM_W - 1)) begin
					state_d = mmop_pkg::SETUP_SIZE;
				end
			end
			mmop_pkg::SETUP_SIZE: begin
				if (k_q == mmop_pkg::LVL_W'(mmop_pkg::MAX_LEVELS - 1)) begin
					state_d = mmop_pkg::SETUP_IDLE;
				end
			end
			default: begin
				state_d = mmop_pkg::SETUP_IDLE;
			end
		endcase
		if (cfg_valid) begin
			state_d = mmop_pkg::SETUP_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmop_pkg::SETUP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			base_q       <= mmop_pkg::BASE_W'(mmop_pkg::BASE_RESET);
			stride_q     <= mmop_pkg::STRIDE_W'(1);
			spb_q        <= mmop_pkg::SPB_W'(mmop_pkg::BASE_RESET);
			size_q       <= '0;
			has_next_q   <= '0;
			num_q        <= '0;
			rem_q        <= '0;
			div_cnt_q    <= '0;
			k_q          <= '0;
			cur_size_q   <= '0;
			cur_exists_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == mmop_pkg::REG_COUNT) begin
					count_q <= cfg_data;
				end else if (cfg_index == mmop_pkg::REG_BASE) begin
					base_q <= (cfg_data[mmop_pkg::BASE_W-1:0] == '0) ? mmop_pkg::BASE_W'(1)
						: cfg_data[mmop_pkg::BASE_W-1:0];
				end
			end else begin
				case (state_q)
					mmop_pkg::SETUP_START: begin
						stride_q  <= stride_c;
						spb_q     <= mmop_pkg::SPB_W'(base_q * stride_c);
						num_q     <= {1'b0, count_q} + mmop_pkg::NUM_W'(stride_c)
							- mmop_pkg::NUM_W'(1);
						rem_q     <= '0;
						div_cnt_q <= '0;
					end
					mmop_pkg::SETUP_DIV: begin
						num_q     <= num_next;
						rem_q     <= rem_sub[mmop_pkg::REM_W-1:0];
						div_cnt_q <= div_cnt_q + mmop_pkg::DIV_CNT_W'(1);
						if (div_cnt_q == mmop_pkg::DIV_CNT_W'(mmop_pkg::NUM_W - 1)) begin
							size_q[0]    <= num_next[mmop_pkg::SIZE_W-1:0];
							cur_size_q   <= num_next[mmop_pkg::SIZE_W-1:0];
							cur_exists_q <= 1'b1;
							has_next_q   <= '0;
							k_q          <= mmop_pkg::LVL_W'(1);
						end
					end
					mmop_pkg::SETUP_SIZE: begin
						size_q[k_q]        <= nxt_size;
						has_next_q[k_prev] <= nxt_exists;
						cur_size_q         <= nxt_size;
						cur_exists_q       <= nxt_exists;
						k_q                <= k_q + mmop_pkg::LVL_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign geom.count    = count_q;
	assign geom.stride   = stride_q;
	assign geom.spb      = spb_q;
	assign geom.size     = size_q;
	assign geom.has_next = has_next_q;

endmodule
`default_nettype wire

// ===== design/mmop_group.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mmop_group (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   clear,
	input  wire                                   busy,
	input  mmop_pkg::geom_t                       geom,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire signed [mmop_pkg::SAMPLE_W-1:0]   in_min,
	input  wire signed [mmop_pkg::SAMPLE_W-1:0]   in_max,
	output logic                                  close_valid,
	input  wire                                   close_ready,
	output mmop_pkg::close_t                      close
);

	logic                               valid_s1;
	logic signed [mmop_pkg::SAMPLE_W-1:0] min_s1;
	logic signed [mmop_pkg::SAMPLE_W-1:0] max_s1;

	logic signed [mmop_pkg::SAMPLE_W-1:0] group_min_q;
	logic signed [mmop_pkg::SAMPLE_W-1:0] group_max_q;
	logic [mmop_pkg::FILL_W-1:0]          group_fill_q;
	logic [mmop_pkg::CNT_W-1:0]           items_seen_q;

	logic                                 live;
	logic signed [mmop_pkg::SAMPLE_W-1:0] new_min;
	logic signed [mmop_pkg::SAMPLE_W-1:0] new_max;
	logic [mmop_pkg::FILL_W:0]            fill_inc;
	logic [mmop_pkg::CNT_W:0]             seen_inc;
	logic                                 closes;
	logic                                 advance;

	always_comb begin
		live     = valid_s1 && (items_seen_q < geom.count);
		new_min  = (min_s1 < group_min_q) ? min_s1 : group_min_q;
		new_max  = (max_s1 > group_max_q) ? max_s1 : group_max_q;
		fill_inc = {1'b0, group_fill_q} + (mmop_pkg::FILL_W + 1)'(1);
		seen_inc = {1'b0, items_seen_q} + (mmop_pkg::CNT_W + 1)'(1);
		closes   = (fill_inc >= (mmop_pkg::FILL_W + 1)'(geom.stride))
			|| (seen_inc >= {1'b0, geom.count});
		advance  = !(live && closes) || close_ready;
	end

	assign close_valid = live && closes;
	assign close.mn    = new_min;
	assign close.mx    = new_max;
	assign in_ready    = !busy && (!valid_s1 || advance);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			min_s1 <= in_min;
			max_s1 <= in_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			group_min_q  <= '0;
			group_max_q  <= '0;
			group_fill_q <= '0;
			items_seen_q <= '0;
		end else if (clear) begin
			valid_s1     <= 1'b0;
			group_min_q  <= '0;
			group_max_q  <= '0;
			group_fill_q <= '0;
			items_seen_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (live && advance) begin
				items_seen_q <= seen_inc[mmop_pkg::CNT_W-1:0];
				if (closes) begin
					group_min_q  <= '0;
					group_max_q  <= '0;
					group_fill_q <= '0;
				end else begin
					group_min_q  <= new_min;
					group_max_q  <= new_max;
					group_fill_q <= fill_inc[mmop_pkg::FILL_W-1:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/mmop_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mmop_walk (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    clear,
	input  mmop_pkg::geom_t                        geom,
	input  wire                                    close_valid,
	output logic                                   close_ready,
	input  mmop_pkg::close_t                       close,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic [mmop_pkg::LVL_W-1:0]             out_level,
	output logic [mmop_pkg::IDX_W-1:0]             out_index,
	output logic [mmop_pkg::SAMPLE_W-1:0]          out_min,
	output logic [mmop_pkg::SAMPLE_W-1:0]          out_max,
	output logic [mmop_pkg::SAMPLES_W-1:0]         out_samples,
	output logic                                   out_last
);

	logic                                 active_q;
	logic [mmop_pkg::LVL_W-1:0]           lv_q;
	logic signed [mmop_pkg::SAMPLE_W-1:0] mn_q;
	logic signed [mmop_pkg::SAMPLE_W-1:0] mx_q;

	logic signed [mmop_pkg::MAX_LEVELS-1:0][mmop_pkg::SAMPLE_W-1:0] pend_min_q;
	logic signed [mmop_pkg::MAX_LEVELS-1:0][mmop_pkg::SAMPLE_W-1:0] pend_max_q;
	logic [mmop_pkg::MAX_LEVELS-1:0]                                pend_valid_q;
	logic [mmop_pkg::MAX_LEVELS-1:0][mmop_pkg::IDX_W-1:0]           next_idx_q;

	logic                                 m_valid_q;
	logic [mmop_pkg::LVL_W-1:0]           m_level_q;
	logic [mmop_pkg::IDX_W-1:0]           m_index_q;
	logic [mmop_pkg::SAMPLE_W-1:0]        m_min_q;
	logic [mmop_pkg::SAMPLE_W-1:0]        m_max_q;
	logic [mmop_pkg::SAMPLES_W-1:0]       m_samples_q;
	logic                                 m_last_q;

	logic                                 emit;
	logic [mmop_pkg::IDX_W-1:0]           idx;
	logic [mmop_pkg::SIZE_W-1:0]          idx_inc;
	logic                                 last_here;
	logic                                 has_next;
	logic                                 pv;
	logic signed [mmop_pkg::SAMPLE_W-1:0] pmn;
	logic signed [mmop_pkg::SAMPLE_W-1:0] pmx;
	logic                                 stop;
	logic                                 load;

	always_comb begin
		emit      = active_q && (!m_valid_q || out_ready);
		idx       = next_idx_q[lv_q];
		idx_inc   = {1'b0, idx} + mmop_pkg::SIZE_W'(1);
		last_here = idx_inc >= geom.size[lv_q];
		has_next  = geom.has_next[lv_q];
		pv        = pend_valid_q[lv_q];
		pmn       = pend_min_q[lv_q];
		pmx       = pend_max_q[lv_q];
		stop      = !has_next || (!pv && !last_here);
		load      = close_valid && close_ready;
	end

	assign close_ready = !active_q || (emit && stop);

	always_ff @(posedge clk) begin
		if (emit) begin
			m_level_q   <= lv_q;
			m_index_q   <= idx;
			m_min_q     <= mn_q;
			m_max_q     <= mx_q;
			m_samples_q <= mmop_pkg::SAMPLES_W'(geom.spb) << lv_q;
			m_last_q    <= stop;
		end
		if (load) begin
			mn_q <= close.mn;
			mx_q <= close.mx;
		end else if (emit && has_next && pv) begin
			if (pmn < mn_q) begin
				mn_q <= pmn;
			end
			if (pmx > mx_q) begin
				mx_q <= pmx;
			end
		end
		if (emit && has_next && !pv && !last_here) begin
			pend_min_q[lv_q] <= mn_q;
			pend_max_q[lv_q] <= mx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			lv_q         <= '0;
			pend_valid_q <= '0;
			next_idx_q   <= '0;
			m_valid_q    <= 1'b0;
		end else if (clear) begin
			active_q     <= 1'b0;
			lv_q         <= '0;
			pend_valid_q <= '0;
			next_idx_q   <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (emit) begin
				m_valid_q        <= 1'b1;
				next_idx_q[lv_q] <= idx + mmop_pkg::IDX_W'(1);
				if (has_next && pv) begin
					pend_valid_q[lv_q] <= 1'b0;
				end else if (has_next && !last_here) begin
					pend_valid_q[lv_q] <= 1'b1;
				end
				if (stop) begin
					active_q <= 1'b0;
				end else begin
					lv_q <= lv_q + mmop_pkg::LVL_W'(1);
				end
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
			if (load) begin
				active_q <= 1'b1;
				lv_q     <= '0;
			end
		end
	end

	assign out_valid   = m_valid_q;
	assign out_level   = m_level_q;
	assign out_index   = m_index_q;
	assign out_min     = m_min_q;
	assign out_max     = m_max_q;
	assign out_samples = m_samples_q;
	assign out_last    = m_last_q;

endmodule
`default_nettype wire
